// ===== rtl/hhr_pkg.sv =====
// hhr_pkg: shared constants, stage types and the hue sector weight function
// for the hsl hue replace recolor pipeline
// no dependencies
package hhr_pkg;

   localparam int HUE_BITS = 16;
   localparam int CSR_W    = 16;
   localparam int BYTE_W   = 8;
   localparam int POS_W    = HUE_BITS + 3;
   localparam int WGT_W    = HUE_BITS + 1;
   localparam int PROD_W   = BYTE_W + WGT_W;
   localparam int SUM_W    = BYTE_W + 2;

   localparam logic signed [POS_W-1:0] HUE_ONE   = POS_W'(1) <<< HUE_BITS;
   localparam logic signed [POS_W-1:0] HUE_HALF  = HUE_ONE >>> 1;
   localparam logic signed [POS_W-1:0] HUE_3HALF = HUE_ONE + HUE_HALF;
   localparam logic signed [POS_W-1:0] HUE_TWO   = HUE_ONE <<< 1;
   localparam logic signed [POS_W-1:0] HUE_THREE = HUE_TWO + HUE_ONE;

   localparam logic signed [POS_W-1:0] SHIFT_A = -HUE_ONE;
   localparam logic signed [POS_W-1:0] SHIFT_B = '0;
   localparam logic signed [POS_W-1:0] SHIFT_C = HUE_ONE;

   typedef struct packed {
      logic [BYTE_W-1:0] base;
      logic [BYTE_W-1:0] span;
      logic [WGT_W-1:0]  weight_a;
      logic [WGT_W-1:0]  weight_b;
      logic [WGT_W-1:0]  weight_c;
   } prep_type;

   typedef struct packed {
      logic [BYTE_W-1:0] base;
      logic [PROD_W-1:0] prod_a;
      logic [PROD_W-1:0] prod_b;
      logic [PROD_W-1:0] prod_c;
   } prod_type;

   typedef struct packed {
      logic [BYTE_W-1:0] a;
      logic [BYTE_W-1:0] b;
      logic [BYTE_W-1:0] c;
   } pix_type;

   // weight of the hsl sector curve at 3*hue + shift, scaled to 2^HUE_BITS
   function automatic logic [WGT_W-1:0] sector_weight(
      input logic [HUE_BITS-1:0]     hue,
      input logic signed [POS_W-1:0] shift
   );
      logic signed [POS_W-1:0] pos;
      logic [WGT_W-1:0]        wgt;
      pos = POS_W'(3 * $signed({3'b000, hue})) + shift;
      if (pos < 0) begin
         pos = pos + HUE_THREE;
      end else if (pos > HUE_THREE) begin
         pos = pos - HUE_THREE;
      end
      priority if (pos < HUE_HALF) begin
         wgt = WGT_W'(pos <<< 1);
      end else if (pos < HUE_3HALF) begin
         wgt = WGT_W'(HUE_ONE);
      end else if (pos < HUE_TWO) begin
         wgt = WGT_W'((HUE_TWO - pos) <<< 1);
      end else begin
         wgt = '0;
      end
      return wgt;
   endfunction

   // saturate a widened sum to one byte
   function automatic logic [BYTE_W-1:0] clamp_byte(input logic [SUM_W-1:0] sum);
      logic [BYTE_W-1:0] res;
      if (sum > SUM_W'({BYTE_W{1'b1}})) begin
         res = '1;
      end else begin
         res = sum[BYTE_W-1:0];
      end
      return res;
   endfunction

endpackage

// ===== rtl/hhr_prep.sv =====
// hhr_prep: first pipeline stage, channel max/min and the three sector weights
// depends on hhr_pkg
module hhr_prep import hhr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  logic [BYTE_W-1:0]   chan_a,
   input  logic [BYTE_W-1:0]   chan_b,
   input  logic [BYTE_W-1:0]   chan_c,
   input  logic [HUE_BITS-1:0] hue,
   output logic                valid_ff,
   output prep_type            data_ff
);

   logic [BYTE_W-1:0] max_ab;
   logic [BYTE_W-1:0] min_ab;
   logic [BYTE_W-1:0] max_all;
   logic [BYTE_W-1:0] min_all;
   prep_type          data_in;

   always_comb begin
      max_ab           = (chan_a > chan_b) ? chan_a : chan_b;
      min_ab           = (chan_a < chan_b) ? chan_a : chan_b;
      max_all          = (chan_c > max_ab) ? chan_c : max_ab;
      min_all          = (chan_c < min_ab) ? chan_c : min_ab;
      data_in.base     = min_all;
      data_in.span     = max_all - min_all;
      data_in.weight_a = sector_weight(hue, SHIFT_A);
      data_in.weight_b = sector_weight(hue, SHIFT_B);
      data_in.weight_c = sector_weight(hue, SHIFT_C);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== rtl/hhr_blend.sv =====
// hhr_blend: second and third pipeline stages, span times weight, then add base
// depends on hhr_pkg
module hhr_blend import hhr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  logic     in_valid,
   input  prep_type in_data,
   output logic     valid_ff,
   output pix_type  data_ff
);

   logic     prod_valid_ff;
   prod_type prod_ff;
   prod_type prod_in;
   pix_type  data_in;

   always_comb begin
      prod_in.base   = in_data.base;
      prod_in.prod_a = PROD_W'(in_data.span) * PROD_W'(in_data.weight_a);
      prod_in.prod_b = PROD_W'(in_data.span) * PROD_W'(in_data.weight_b);
      prod_in.prod_c = PROD_W'(in_data.span) * PROD_W'(in_data.weight_c);
   end

   always_comb begin
      data_in.a = clamp_byte(SUM_W'(prod_ff.base) + SUM_W'(prod_ff.prod_a[PROD_W-1:HUE_BITS]));
      data_in.b = clamp_byte(SUM_W'(prod_ff.base) + SUM_W'(prod_ff.prod_b[PROD_W-1:HUE_BITS]));
      data_in.c = clamp_byte(SUM_W'(prod_ff.base) + SUM_W'(prod_ff.prod_c[PROD_W-1:HUE_BITS]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         valid_ff      <= 1'b0;
      end else if (advance) begin
         prod_valid_ff <= in_valid;
         valid_ff      <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         data_ff <= data_in;
      end
   end

endmodule

// ===== rtl/hhr_outbuf.sv =====
// hhr_outbuf: output register with one skid entry, holds the pipeline on stall
// depends on hhr_pkg
module hhr_outbuf import hhr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  pix_type in_data,
   output logic    in_ready,
   output logic    out_valid,
   input  logic    out_ready,
   output pix_type out_data
);

   logic    out_valid_ff;
   logic    out_valid_in;
   logic    skid_valid_ff;
   logic    skid_valid_in;
   pix_type out_ff;
   pix_type skid_ff;
   logic    push;
   logic    pop;
   logic    load_out;
   logic    load_skid;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;
   assign push      = in_valid && !skid_valid_ff;
   assign pop       = out_valid_ff && out_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      load_out      = 1'b0;
      load_skid     = 1'b0;
      if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_in = 1'b0;
            load_out      = 1'b1;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_valid_in = 1'b1;
            load_out     = 1'b1;
         end else begin
            skid_valid_in = 1'b1;
            load_skid     = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_ff <= skid_valid_ff ? skid_ff : in_data;
      end
      if (load_skid) begin
         skid_ff <= in_data;
      end
   end

endmodule

// ===== rtl/hsl_hue_replace_recolor_core.sv =====
// hsl_hue_replace_recolor_core: top level of the pixel recolor pipeline
// depends on hhr_pkg, hhr_prep, hhr_blend, hhr_outbuf
//
// usage
// - req channel: one pixel word (req_chan_a/b/c) per valid/ready handshake
// - rsp channel: one recolored word (rsp_out_a/b/c) per pixel, in order
// - csr port: csr_write_en with csr_write_data sets the replacement hue,
//   taken at once; write it only while no pixel is in flight
// - path: a pixel passes three compute registers, the first loaded at the
//   req handshake edge, then the output register, before rsp_valid rises
// - throughput: one pixel per cycle while req_ready is high, set by the
//   three-stage pipeline with one multiplier per channel in the middle stage
// - stall: when rsp_ready is low the result sits in the output register,
//   one more word lands in the skid entry, and req_ready drops the cycle
//   after until the skid entry drains; nothing is dropped or repeated
// - reset: synchronous, active high; clears all valid bits and sets the
//   hue to zero
module hsl_hue_replace_recolor_core import hhr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_chan_a,
   input  logic [BYTE_W-1:0] req_chan_b,
   input  logic [BYTE_W-1:0] req_chan_c,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BYTE_W-1:0] rsp_out_a,
   output logic [BYTE_W-1:0] rsp_out_b,
   output logic [BYTE_W-1:0] rsp_out_c,
   input  logic              csr_write_en,
   input  logic [CSR_W-1:0]  csr_write_data
);

   logic [HUE_BITS-1:0] hue_ff;
   logic                advance;
   logic                prep_valid;
   prep_type            prep_data;
   logic                blend_valid;
   pix_type             blend_data;
   pix_type             rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_ff <= '0;
      end else if (csr_write_en) begin
         hue_ff <= HUE_BITS'(csr_write_data);
      end
   end

   assign req_ready = advance;

   hhr_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_valid),
      .chan_a   (req_chan_a),
      .chan_b   (req_chan_b),
      .chan_c   (req_chan_c),
      .hue      (hue_ff),
      .valid_ff (prep_valid),
      .data_ff  (prep_data)
   );

   hhr_blend u_blend (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (prep_valid),
      .in_data  (prep_data),
      .valid_ff (blend_valid),
      .data_ff  (blend_data)
   );

   hhr_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (blend_valid),
      .in_data   (blend_data),
      .in_ready  (advance),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_out_a = rsp_data.a;
   assign rsp_out_b = rsp_data.b;
   assign rsp_out_c = rsp_data.c;

endmodule

// ===== bench/hhr_recolor_checker.sv =====
`timescale 1ns / 100ps
// hhr_recolor_checker: watches the req, rsp and csr ports of the hue replace core,
// predicts each recolored word from its own hue copy and compares field by field
// depends on hhr_pkg
module hhr_recolor_checker import hhr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [BYTE_W-1:0] req_chan_a,
   input  logic [BYTE_W-1:0] req_chan_b,
   input  logic [BYTE_W-1:0] req_chan_c,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [BYTE_W-1:0] rsp_out_a,
   input  logic [BYTE_W-1:0] rsp_out_b,
   input  logic [BYTE_W-1:0] rsp_out_c,
   input  logic              csr_write_en,
   input  logic [CSR_W-1:0]  csr_write_data,
   output int                error_count,
   output int                words_pending
);

   logic [CSR_W-1:0] hue_copy;
   pix_type          recolored_words[$];
   pix_type          got_word;
   pix_type          want_word;
   pix_type          pred_word;
   int               fail_tally   = 0;
   int               checked_words = 0;

   assign error_count   = fail_tally;
   assign words_pending = recolored_words.size();

   // level of the hsl sector curve at a hue position in thirds of 2^HUE_BITS
   function automatic logic [BYTE_W-1:0] curve_level(input int lo, input int hi, input int pos);
      int     turn;
      int     k;
      int     v;
      longint scaled;
      turn = 1 << HUE_BITS;
      if (pos < 0) begin
         pos = pos + 3 * turn;
      end else if (pos > 3 * turn) begin
         pos = pos - 3 * turn;
      end
      if (2 * pos < turn) begin
         k = 2 * pos;
      end else if (2 * pos < 3 * turn) begin
         k = turn;
      end else if (pos < 2 * turn) begin
         k = 4 * turn - 2 * pos;
      end else begin
         k = 0;
      end
      scaled = longint'(hi - lo) * longint'(k);
      v = lo - 1 + int'(scaled >>> HUE_BITS);
      if (v < 0) begin
         v = 0;
      end
      if (v > 255) begin
         v = 255;
      end
      return v[BYTE_W-1:0];
   endfunction

   function automatic pix_type recolor_pixel(input logic [CSR_W-1:0] hue, input pix_type px);
      int      ca;
      int      cb;
      int      cc;
      int      top;
      int      bottom;
      int      turn;
      int      t;
      pix_type res;
      ca = px.a + 1;
      cb = px.b + 1;
      cc = px.c + 1;
      top = ca;
      bottom = ca;
      if (cb > top) top = cb;
      if (cc > top) top = cc;
      if (cb < bottom) bottom = cb;
      if (cc < bottom) bottom = cc;
      if (top == bottom) begin
         res.a = BYTE_W'(top - 1);
         res.b = BYTE_W'(top - 1);
         res.c = BYTE_W'(top - 1);
      end else begin
         turn = 1 << HUE_BITS;
         t = int'(hue) & (turn - 1);
         res.a = curve_level(bottom, top, 3 * t - turn);
         res.b = curve_level(bottom, top, 3 * t);
         res.c = curve_level(bottom, top, 3 * t + turn);
      end
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      fail_tally++;
   endtask

   task automatic compare_field(input string name, input logic [BYTE_W-1:0] got,
                                input logic [BYTE_W-1:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("word %0d %s got %0d want %0d", checked_words, name, got,
                                   want));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         hue_copy = '0;
         recolored_words.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got_word = '{a: rsp_out_a, b: rsp_out_b, c: rsp_out_c};
            if (recolored_words.size() == 0) begin
               report_mismatch($sformatf("result word %0h with no pixel in flight", got_word));
            end else begin
               want_word = recolored_words.pop_front();
               compare_field("out_a", got_word.a, want_word.a);
               compare_field("out_b", got_word.b, want_word.b);
               compare_field("out_c", got_word.c, want_word.c);
            end
            checked_words++;
         end
         if (req_valid && req_ready) begin
            pred_word = recolor_pixel(hue_copy,
               '{a: req_chan_a, b: req_chan_b, c: req_chan_c});
            recolored_words = {recolored_words, pred_word};
         end
         if (csr_write_en) begin
            hue_copy = csr_write_data;
         end
      end
   end

endmodule

// ===== bench/tb_hsl_hue_replace_recolor_core.sv =====
`timescale 1ns / 100ps
// tb_hsl_hue_replace_recolor_core: pixel stimulus, hue writes, random stalls and verdict
// depends on hhr_pkg, hsl_hue_replace_recolor_core and hhr_recolor_checker
module tb_hsl_hue_replace_recolor_core;
   import hhr_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int BLOCK_COUNT  = 6;
   localparam int BLOCK_PIXELS = 250;
   localparam int DRAIN_CYCLES = 20;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [BYTE_W-1:0] req_chan_a;
   logic [BYTE_W-1:0] req_chan_b;
   logic [BYTE_W-1:0] req_chan_c;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [BYTE_W-1:0] rsp_out_a;
   logic [BYTE_W-1:0] rsp_out_b;
   logic [BYTE_W-1:0] rsp_out_c;
   logic              csr_write_en;
   logic [CSR_W-1:0]  csr_write_data;
   int                error_count;
   int                words_pending;
   int                cycle_count = 0;
   int                tx_idle_pct = 0;
   int                rx_idle_pct = 0;

   hsl_hue_replace_recolor_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_chan_a     (req_chan_a),
      .req_chan_b     (req_chan_b),
      .req_chan_c     (req_chan_c),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_a      (rsp_out_a),
      .rsp_out_b      (rsp_out_b),
      .rsp_out_c      (rsp_out_c),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   hhr_recolor_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_chan_a     (req_chan_a),
      .req_chan_b     (req_chan_b),
      .req_chan_c     (req_chan_c),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_a      (rsp_out_a),
      .rsp_out_b      (rsp_out_b),
      .rsp_out_c      (rsp_out_c),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .error_count    (error_count),
      .words_pending  (words_pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   task automatic push_pixel(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b,
                             input logic [BYTE_W-1:0] c);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_chan_a <= a;
      req_chan_b <= b;
      req_chan_c <= c;
      do begin
         @(posedge clock);
      end while (!req_ready);
   endtask

   // drop valid, let the pipeline drain, then write the hue
   task automatic write_hue(input logic [CSR_W-1:0] hue);
      @(negedge clock);
      req_valid <= 1'b0;
      while (words_pending != 0) begin
         @(negedge clock);
      end
      repeat (8) @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= hue;
      @(negedge clock);
      csr_write_en   <= 1'b0;
   endtask

   initial begin
      logic [CSR_W-1:0]  hue_plan [BLOCK_COUNT];
      logic [BYTE_W-1:0] pa;
      logic [BYTE_W-1:0] pb;
      logic [BYTE_W-1:0] pc;
      int                sel;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_chan_a     = '0;
      req_chan_b     = '0;
      req_chan_c     = '0;
      rsp_ready      = 1'b0;
      csr_write_en   = 1'b0;
      csr_write_data = '0;
      hue_plan[0] = 16'hFFFF;
      hue_plan[1] = 16'h0000;
      hue_plan[2] = 16'h2AAB;
      hue_plan[3] = 16'h8000;
      hue_plan[4] = CSR_W'($urandom);
      hue_plan[5] = CSR_W'($urandom);

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // corners at the reset hue
      push_pixel(8'h00, 8'h00, 8'h00);
      push_pixel(8'hFF, 8'hFF, 8'hFF);
      push_pixel(8'h80, 8'h80, 8'h80);
      push_pixel(8'hFF, 8'h00, 8'h00);
      push_pixel(8'h00, 8'hFF, 8'h00);
      push_pixel(8'h00, 8'h00, 8'hFF);
      push_pixel(8'h00, 8'hFF, 8'hFF);
      push_pixel(8'hFF, 8'h00, 8'hFF);
      push_pixel(8'hFF, 8'hFF, 8'h00);
      push_pixel(8'h01, 8'h00, 8'h00);
      push_pixel(8'hFE, 8'hFF, 8'hFF);
      push_pixel(8'h7F, 8'h80, 8'h7F);
      push_pixel(8'h00, 8'h80, 8'hFF);
      push_pixel(8'hC8, 8'h64, 8'h32);
      push_pixel(8'h11, 8'h11, 8'h12);
      push_pixel(8'hAA, 8'h55, 8'hAA);
      push_pixel(8'h55, 8'hAA, 8'h55);
      push_pixel(8'h3F, 8'hBF, 8'h7F);

      for (int blk = 0; blk < BLOCK_COUNT; blk++) begin
         write_hue(hue_plan[blk]);
         if (blk < 2) begin
            tx_idle_pct = 10;
            rx_idle_pct = 84;
         end else if (blk < 4) begin
            tx_idle_pct = 84;
            rx_idle_pct = 10;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         for (int n = 0; n < BLOCK_PIXELS; n++) begin
            sel = $urandom_range(9);
            pa = BYTE_W'($urandom);
            pb = BYTE_W'($urandom);
            pc = BYTE_W'($urandom);
            if (sel == 0) begin
               pb = pa;
               pc = pa;
            end else if (sel == 1) begin
               pa = $urandom_range(1) ? 8'hFF : 8'h00;
               pc = $urandom_range(1) ? 8'hFF : 8'h00;
            end else if (sel == 2) begin
               pb = pa + BYTE_W'($urandom_range(2));
               pc = pa;
            end
            push_pixel(pa, pb, pc);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (words_pending != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
